// File: rtl/hsv2rgb_pkg.sv
// Shared types and constants for the HSV to RGB pixel converter.
// No dependencies; every rtl module imports this package.
package hsv2rgb_pkg;

	localparam int DEF_COMPONENT_BITS = 8;
	localparam int DEF_HUE_FRAC_BITS  = 6;

	// hue carries 9 integer bits of degrees above its fraction bits
	localparam int HUE_INT_BITS = 9;
	localparam int SECTOR_DEG   = 60;
	localparam int NUM_SECTORS  = 6;
	localparam int SECTOR_BITS  = 3;

	localparam int QUEUE_DEPTH = 2;

	// product lanes of the back end
	localparam int NUM_LANES = 3;
	localparam int LANE_P    = 0;
	localparam int LANE_Q    = 1;
	localparam int LANE_T    = 2;

	typedef enum logic [SECTOR_BITS-1:0] {
		SEC_RED_YEL = 3'd0,
		SEC_YEL_GRN = 3'd1,
		SEC_GRN_CYN = 3'd2,
		SEC_CYN_BLU = 3'd3,
		SEC_BLU_MAG = 3'd4,
		SEC_MAG_RED = 3'd5
	} sector_t;

endpackage

// File: rtl/hsv2rgb_front.sv
// Front end: wraps the hue, finds its 60 degree sector and the offset within it.
// Depends on hsv2rgb_pkg.
module hsv2rgb_front #(
	parameter int COMPONENT_BITS = hsv2rgb_pkg::DEF_COMPONENT_BITS,
	parameter int HUE_FRAC_BITS  = hsv2rgb_pkg::DEF_HUE_FRAC_BITS
) (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_stall,
	input  logic [hsv2rgb_pkg::HUE_INT_BITS+HUE_FRAC_BITS-1:0] hue,
	input  logic [COMPONENT_BITS-1:0] saturation,
	input  logic [COMPONENT_BITS-1:0] brightness,
	output logic fwd_valid,
	input  logic fwd_stall,
	output hsv2rgb_pkg::sector_t fwd_sector,
	output logic [$clog2(hsv2rgb_pkg::SECTOR_DEG << HUE_FRAC_BITS)-1:0] fwd_frac,
	output logic [COMPONENT_BITS-1:0] fwd_sat,
	output logic [COMPONENT_BITS-1:0] fwd_val
);
	import hsv2rgb_pkg::*;

	localparam int HW   = HUE_INT_BITS + HUE_FRAC_BITS;
	localparam int K    = SECTOR_DEG << HUE_FRAC_BITS;
	localparam int FW   = $clog2(K);
	localparam int FULL = NUM_SECTORS * K;

	logic [HW-1:0] hue_w;
	logic [HW-1:0] base_c;
	sector_t       sector_c;
	logic [FW-1:0] frac_c;
	logic          load;

	logic          valid_s1;
	sector_t       sector_s1;
	logic [FW-1:0] frac_s1;
	logic [COMPONENT_BITS-1:0] sat_s1;
	logic [COMPONENT_BITS-1:0] val_s1;

	// a full turn or more drops back by one turn
	assign hue_w = (hue >= HW'(FULL)) ? hue - HW'(FULL) : hue;

	always_comb begin
		sector_c = SEC_RED_YEL;
		base_c   = '0;
		for (int k = 1; k < NUM_SECTORS; k++) begin
			if (hue_w >= HW'(k * K)) begin
				sector_c = sector_t'(k);
				base_c   = HW'(k * K);
			end
		end
	end

	assign frac_c = FW'(hue_w - base_c);

	assign load     = !valid_s1 || !fwd_stall;
	assign in_stall = valid_s1 && fwd_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (load) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (load && in_valid) begin
			sector_s1 <= sector_c;
			frac_s1   <= frac_c;
			sat_s1    <= saturation;
			val_s1    <= brightness;
		end
	end

	assign fwd_valid  = valid_s1;
	assign fwd_sector = sector_s1;
	assign fwd_frac   = frac_s1;
	assign fwd_sat    = sat_s1;
	assign fwd_val    = val_s1;

endmodule

// File: rtl/hsv2rgb_queue.sv
// Short queue that decouples the front end from the back end.
// Depends on hsv2rgb_pkg for its depth.
module hsv2rgb_queue #(
	parameter int WIDTH = 8
) (
	input  logic clk,
	input  logic arst_n,
	input  logic wr_valid,
	output logic wr_stall,
	input  logic [WIDTH-1:0] wr_data,
	output logic rd_valid,
	input  logic rd_stall,
	output logic [WIDTH-1:0] rd_data
);
	import hsv2rgb_pkg::*;

	localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CW = $clog2(QUEUE_DEPTH + 1);

	logic [WIDTH-1:0] mem_q [QUEUE_DEPTH];
	logic [PW-1:0]    wr_ptr_q;
	logic [PW-1:0]    rd_ptr_q;
	logic [CW-1:0]    count_q;
	logic             push;
	logic             pop;

	assign wr_stall = (count_q == CW'(QUEUE_DEPTH));
	assign rd_valid = (count_q != '0);
	assign push     = wr_valid && !wr_stall;
	assign pop      = rd_valid && !rd_stall;
	assign rd_data  = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

endmodule

// File: rtl/hsv2rgb_back.sv
// Back end: forms p, q and t with a reciprocal multiply by a constant and routes them by sector.
// Depends on hsv2rgb_pkg.
module hsv2rgb_back #(
	parameter int COMPONENT_BITS = hsv2rgb_pkg::DEF_COMPONENT_BITS,
	parameter int HUE_FRAC_BITS  = hsv2rgb_pkg::DEF_HUE_FRAC_BITS
) (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_stall,
	input  hsv2rgb_pkg::sector_t sector,
	input  logic [$clog2(hsv2rgb_pkg::SECTOR_DEG << HUE_FRAC_BITS)-1:0] frac,
	input  logic [COMPONENT_BITS-1:0] sat,
	input  logic [COMPONENT_BITS-1:0] val,
	output logic out_valid,
	input  logic out_stall,
	output logic [COMPONENT_BITS-1:0] red,
	output logic [COMPONENT_BITS-1:0] green,
	output logic [COMPONENT_BITS-1:0] blue
);
	import hsv2rgb_pkg::*;

	localparam int CB  = COMPONENT_BITS;
	localparam int K   = SECTOR_DEG << HUE_FRAC_BITS;
	localparam int KWD = $clog2(K + 1);
	localparam int PW  = KWD + CB;
	localparam longint unsigned M  = (64'd1 << CB) - 64'd1;
	localparam longint unsigned KM = longint'(K) * M;
	localparam int KMW = $clog2(KM + 1);
	localparam int XW  = KMW + CB;
	// K*M is (SECTOR_DEG*M) << HUE_FRAC_BITS: drop the power of two first, then
	// multiply by the rounded-up reciprocal of the rest; the shift RS is wide
	// enough that the floor is exact for every numerator that fits in NW bits
	localparam longint unsigned DV = longint'(SECTOR_DEG) * M;
	localparam int NW  = XW - HUE_FRAC_BITS;
	localparam int RS  = NW + $clog2(DV);
	localparam longint unsigned RECIP = ((64'd1 << RS) + DV - 64'd1) / DV;
	localparam int RW  = $clog2(RECIP + 1);
	localparam int MW  = NW + RW;

	logic advance;

	// stage 1: weight times saturation per lane
	logic             valid_s1;
	sector_t          sector_s1;
	logic [CB-1:0]    val_s1;
	logic [PW-1:0]    prod_s1 [NUM_LANES];
	logic [KWD-1:0]   weight_c [NUM_LANES];

	// stage 2: numerator v * (K*M - w*s) per lane
	logic             valid_s2;
	sector_t          sector_s2;
	logic [CB-1:0]    val_s2;
	logic [XW-1:0]    num_s2 [NUM_LANES];

	// stage 3: quotient by K*M per lane
	logic             valid_s3;
	sector_t          sector_s3;
	logic [CB-1:0]    val_s3;
	logic [CB-1:0]    quo_s3 [NUM_LANES];
	logic [MW-1:0]    scaled_c [NUM_LANES];

	logic             out_valid_q;
	logic [CB-1:0]    red_q;
	logic [CB-1:0]    green_q;
	logic [CB-1:0]    blue_q;
	logic [CB-1:0]    red_c;
	logic [CB-1:0]    green_c;
	logic [CB-1:0]    blue_c;

	// whole pipe holds while a finished pixel waits at the output
	assign advance  = !(out_valid_q && out_stall);
	assign in_stall = !advance;

	assign weight_c[LANE_P] = KWD'(K);
	assign weight_c[LANE_Q] = KWD'(frac);
	assign weight_c[LANE_T] = KWD'(K) - KWD'(frac);

	always_comb begin
		for (int l = 0; l < NUM_LANES; l++) begin
			scaled_c[l] = MW'(NW'(num_s2[l] >> HUE_FRAC_BITS)) * MW'(RECIP);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			valid_s2    <= 1'b0;
			valid_s3    <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (advance) begin
			valid_s1    <= in_valid;
			valid_s2    <= valid_s1;
			valid_s3    <= valid_s2;
			out_valid_q <= valid_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			sector_s1 <= sector;
			val_s1    <= val;
			sector_s2 <= sector_s1;
			val_s2    <= val_s1;
			sector_s3 <= sector_s2;
			val_s3    <= val_s2;
			for (int l = 0; l < NUM_LANES; l++) begin
				prod_s1[l] <= PW'(weight_c[l]) * PW'(sat);
				num_s2[l]  <= XW'(val_s1) * XW'(KMW'(KM) - KMW'(prod_s1[l]));
				quo_s3[l]  <= CB'(scaled_c[l] >> RS);
			end
		end
	end

	// route v, p, q, t to the color channels by sector
	always_comb begin
		case (sector_s3)
			SEC_RED_YEL: begin
				red_c   = val_s3;
				green_c = quo_s3[LANE_T];
				blue_c  = quo_s3[LANE_P];
			end
			SEC_YEL_GRN: begin
				red_c   = quo_s3[LANE_Q];
				green_c = val_s3;
				blue_c  = quo_s3[LANE_P];
			end
			SEC_GRN_CYN: begin
				red_c   = quo_s3[LANE_P];
				green_c = val_s3;
				blue_c  = quo_s3[LANE_T];
			end
			SEC_CYN_BLU: begin
				red_c   = quo_s3[LANE_P];
				green_c = quo_s3[LANE_Q];
				blue_c  = val_s3;
			end
			SEC_BLU_MAG: begin
				red_c   = quo_s3[LANE_T];
				green_c = quo_s3[LANE_P];
				blue_c  = val_s3;
			end
			default: begin
				red_c   = val_s3;
				green_c = quo_s3[LANE_P];
				blue_c  = quo_s3[LANE_Q];
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			red_q   <= red_c;
			green_q <= green_c;
			blue_q  <= blue_c;
		end
	end

	assign out_valid = out_valid_q;
	assign red       = red_q;
	assign green     = green_q;
	assign blue      = blue_q;

endmodule

// File: rtl/hsv_to_rgb_pixel.sv
// Top level of the HSV to RGB pixel converter.
// Depends on hsv2rgb_pkg, hsv2rgb_front, hsv2rgb_queue and hsv2rgb_back.
//
// Usage:
//   Input channel (in_valid / in_stall) takes one HSV pixel per item: hue in
//   1/2^HUE_FRAC_BITS degree units (a full turn or more wraps back by one turn),
//   saturation and brightness as COMPONENT_BITS-bit fractions of one.
//   Output channel (out_valid / out_stall) gives one RGB item per input item,
//   in order, each component truncated to COMPONENT_BITS bits.
//   Throughput: one item per clock when the receiver does not stall.
//   The front register loads on the accepting edge; the item then passes the
//   queue entry, the three arithmetic stages of the back end (weight, numerator,
//   reciprocal quotient) and the output register, where out_valid rises.
//   Reset clears every valid flag and the queue; no item is in flight after it.
//   When the receiver stalls, the result holds at the output register and the
//   back pipeline freezes; the two-entry queue and the front stage then fill,
//   and in_stall rises only once all of them are full.
module hsv_to_rgb_pixel #(
	parameter int COMPONENT_BITS = hsv2rgb_pkg::DEF_COMPONENT_BITS,
	parameter int HUE_FRAC_BITS  = hsv2rgb_pkg::DEF_HUE_FRAC_BITS
) (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_stall,
	input  logic [hsv2rgb_pkg::HUE_INT_BITS+HUE_FRAC_BITS-1:0] hue,
	input  logic [COMPONENT_BITS-1:0] saturation,
	input  logic [COMPONENT_BITS-1:0] brightness,
	output logic out_valid,
	input  logic out_stall,
	output logic [COMPONENT_BITS-1:0] red,
	output logic [COMPONENT_BITS-1:0] green,
	output logic [COMPONENT_BITS-1:0] blue
);
	import hsv2rgb_pkg::*;

	localparam int CB = COMPONENT_BITS;
	localparam int FW = $clog2(SECTOR_DEG << HUE_FRAC_BITS);
	localparam int QW = SECTOR_BITS + FW + 2 * CB;

	// front end to queue
	logic          fe_valid;
	logic          fe_stall;
	sector_t       fe_sector;
	logic [FW-1:0] fe_frac;
	logic [CB-1:0] fe_sat;
	logic [CB-1:0] fe_val;

	// queue to back end
	logic          q_valid;
	logic          q_stall;
	logic [QW-1:0] q_data;
	sector_t       be_sector;
	logic [FW-1:0] be_frac;
	logic [CB-1:0] be_sat;
	logic [CB-1:0] be_val;

	hsv2rgb_front #(
		.COMPONENT_BITS (COMPONENT_BITS),
		.HUE_FRAC_BITS  (HUE_FRAC_BITS)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.hue        (hue),
		.saturation (saturation),
		.brightness (brightness),
		.fwd_valid  (fe_valid),
		.fwd_stall  (fe_stall),
		.fwd_sector (fe_sector),
		.fwd_frac   (fe_frac),
		.fwd_sat    (fe_sat),
		.fwd_val    (fe_val)
	);

	// hold classified items here so front and back stall independently
	hsv2rgb_queue #(
		.WIDTH (QW)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_valid (fe_valid),
		.wr_stall (fe_stall),
		.wr_data  ({fe_sector, fe_frac, fe_sat, fe_val}),
		.rd_valid (q_valid),
		.rd_stall (q_stall),
		.rd_data  (q_data)
	);

	// unpack in the same field order as packed above
	assign be_sector = sector_t'(q_data[QW-1 -: SECTOR_BITS]);
	assign be_frac   = q_data[2*CB +: FW];
	assign be_sat    = q_data[CB +: CB];
	assign be_val    = q_data[0 +: CB];

	hsv2rgb_back #(
		.COMPONENT_BITS (COMPONENT_BITS),
		.HUE_FRAC_BITS  (HUE_FRAC_BITS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (q_valid),
		.in_stall  (q_stall),
		.sector    (be_sector),
		.frac      (be_frac),
		.sat       (be_sat),
		.val       (be_val),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.red       (red),
		.green     (green),
		.blue      (blue)
	);

endmodule

// File: tb/sv/hsv_to_rgb_checker.sv
// Scoreboard for the HSV to RGB pixel converter: watches both channels,
// predicts each RGB item from the accepted HSV item and compares in order.
// Depends on hsv2rgb_pkg for widths, sector naming and hue scaling.
module hsv_to_rgb_checker (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	input  logic in_stall,
	input  logic [hsv2rgb_pkg::HUE_INT_BITS+hsv2rgb_pkg::DEF_HUE_FRAC_BITS-1:0] hue,
	input  logic [hsv2rgb_pkg::DEF_COMPONENT_BITS-1:0] saturation,
	input  logic [hsv2rgb_pkg::DEF_COMPONENT_BITS-1:0] brightness,
	input  logic out_valid,
	input  logic out_stall,
	input  logic [hsv2rgb_pkg::DEF_COMPONENT_BITS-1:0] red,
	input  logic [hsv2rgb_pkg::DEF_COMPONENT_BITS-1:0] green,
	input  logic [hsv2rgb_pkg::DEF_COMPONENT_BITS-1:0] blue,
	output int mismatches,
	output int pixels_checked,
	output int pixels_in_flight
);
	timeunit 1ns;
	timeprecision 1ps;

	import hsv2rgb_pkg::*;

	localparam int CW    = DEF_COMPONENT_BITS;
	localparam int HUE_W = HUE_INT_BITS + DEF_HUE_FRAC_BITS;
	localparam longint unsigned COMP_MAX    = (64'd1 << CW) - 1;
	localparam longint unsigned SECTOR_SPAN = longint'(SECTOR_DEG) << DEF_HUE_FRAC_BITS;
	localparam longint unsigned FULL_TURN   = NUM_SECTORS * SECTOR_SPAN;
	localparam int MAX_PRINTED = 40;

	typedef struct {
		logic [HUE_W-1:0] hue;
		logic [CW-1:0]    sat;
		logic [CW-1:0]    val;
		logic [CW-1:0]    red;
		logic [CW-1:0]    green;
		logic [CW-1:0]    blue;
	} rgb_expect_t;

	rgb_expect_t rgb_expected[$];

	initial begin
		mismatches       = 0;
		pixels_checked   = 0;
		pixels_in_flight = 0;
	end

	function automatic rgb_expect_t rgb_from_hsv(input logic [HUE_W-1:0] h,
			input logic [CW-1:0] s, input logic [CW-1:0] v);
		longint unsigned angle, frac, km, vv, ss, p_lvl, q_lvl, t_lvl;
		longint unsigned r_lvl, g_lvl, b_lvl;
		sector_t sector;
		rgb_expect_t px;
		angle = h;
		// one turn back for a full turn and beyond
		if (angle >= FULL_TURN)
			angle -= FULL_TURN;
		sector = sector_t'(angle / SECTOR_SPAN);
		frac   = angle % SECTOR_SPAN;
		km     = SECTOR_SPAN * COMP_MAX;
		vv     = v;
		ss     = s;
		p_lvl  = (vv * (COMP_MAX - ss)) / COMP_MAX;
		q_lvl  = (vv * (km - frac * ss)) / km;
		t_lvl  = (vv * (km - (SECTOR_SPAN - frac) * ss)) / km;
		case (sector)
			SEC_RED_YEL: begin r_lvl = vv;    g_lvl = t_lvl; b_lvl = p_lvl; end
			SEC_YEL_GRN: begin r_lvl = q_lvl; g_lvl = vv;    b_lvl = p_lvl; end
			SEC_GRN_CYN: begin r_lvl = p_lvl; g_lvl = vv;    b_lvl = t_lvl; end
			SEC_CYN_BLU: begin r_lvl = p_lvl; g_lvl = q_lvl; b_lvl = vv;    end
			SEC_BLU_MAG: begin r_lvl = t_lvl; g_lvl = p_lvl; b_lvl = vv;    end
			default: begin r_lvl = vv; g_lvl = p_lvl; b_lvl = q_lvl; end
		endcase
		px.hue   = h;
		px.sat   = s;
		px.val   = v;
		px.red   = r_lvl[CW-1:0];
		px.green = g_lvl[CW-1:0];
		px.blue  = b_lvl[CW-1:0];
		return px;
	endfunction

	task automatic report_mismatch(input string what);
		mismatches++;
		if (mismatches <= MAX_PRINTED)
			$display("%0t ns: mismatch: %s", $time, what);
	endtask

	task automatic check_component(input string name, input logic [CW-1:0] got,
			input logic [CW-1:0] want, input rgb_expect_t px);
		if (got !== want)
			report_mismatch($sformatf("%s got %0d want %0d (hue %0d sat %0d val %0d)",
				name, got, want, px.hue, px.sat, px.val));
	endtask

	always @(posedge clk) begin
		rgb_expect_t px;
		if (arst_n) begin
			if (in_valid && !in_stall)
				rgb_expected.push_back(rgb_from_hsv(hue, saturation, brightness));
			if (out_valid && !out_stall) begin
				if (rgb_expected.size() == 0) begin
					report_mismatch($sformatf("unexpected item r %0d g %0d b %0d",
						red, green, blue));
				end else begin
					px = rgb_expected.pop_front();
					check_component("red", red, px.red, px);
					check_component("green", green, px.green, px);
					check_component("blue", blue, px.blue, px);
					pixels_checked <= pixels_checked + 1;
				end
			end
		end
		pixels_in_flight <= rgb_expected.size();
	end

endmodule

// File: tb/sv/tb_hsv_to_rgb_pixel.sv
// Testbench top for the HSV to RGB pixel converter: clock, reset, stimulus
// and verdict. Depends on hsv2rgb_pkg, hsv_to_rgb_pixel and hsv_to_rgb_checker.
module tb_hsv_to_rgb_pixel;
	timeunit 1ns;
	timeprecision 1ps;

	import hsv2rgb_pkg::*;

	localparam int CW          = DEF_COMPONENT_BITS;
	localparam int HUE_W       = HUE_INT_BITS + DEF_HUE_FRAC_BITS;
	localparam int HUE_MAX     = (1 << HUE_W) - 1;
	localparam int COMP_TOP    = (1 << CW) - 1;
	localparam int SECTOR_SPAN = SECTOR_DEG << DEF_HUE_FRAC_BITS;
	localparam int FULL_TURN   = NUM_SECTORS * SECTOR_SPAN;
	// clock edges from the accepting edge to out_valid rising
	localparam int LATENCY     = 5;
	localparam int PHASE_ITEMS = 225;
	localparam int NUM_PHASES  = 4;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic [HUE_W-1:0] hue = '0;
	logic [CW-1:0] saturation = '0;
	logic [CW-1:0] brightness = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic [CW-1:0] red, green, blue;

	int mismatches, pixels_checked, pixels_in_flight;
	int pixels_sent = 0;

	// pacing, in percent of cycles, for the sender's gaps and the receiver's stalls
	int send_idle_pct = 0;
	int recv_stall_pct = 0;

	// pacing per phase: none, sender sparse, receiver sparse, light on both
	int phase_send[NUM_PHASES] = '{0, 88, 0, 6};
	int phase_recv[NUM_PHASES] = '{0, 0, 88, 6};

	always #5 clk = ~clk;

	hsv_to_rgb_pixel dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.hue        (hue),
		.saturation (saturation),
		.brightness (brightness),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.red        (red),
		.green      (green),
		.blue       (blue)
	);

	hsv_to_rgb_checker scoreboard (
		.clk              (clk),
		.arst_n           (arst_n),
		.in_valid         (in_valid),
		.in_stall         (in_stall),
		.hue              (hue),
		.saturation       (saturation),
		.brightness       (brightness),
		.out_valid        (out_valid),
		.out_stall        (out_stall),
		.red              (red),
		.green            (green),
		.blue             (blue),
		.mismatches       (mismatches),
		.pixels_checked   (pixels_checked),
		.pixels_in_flight (pixels_in_flight)
	);

	// Receiver: redraw the stall each cycle from the current phase's rate.
	always @(posedge clk) begin
		out_stall <= ($urandom_range(99) < recv_stall_pct);
	end

	// Offer one pixel. Insert random idle cycles first, then hold the payload
	// until the item is taken. Returns at the accepting edge with in_valid
	// still high, so a following item keeps valid up without a dip.
	task automatic send_pixel(input int h, input int s, input int v);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		hue        <= h[HUE_W-1:0];
		saturation <= s[CW-1:0];
		brightness <= v[CW-1:0];
		in_valid   <= 1'b1;
		do
			@(posedge clk);
		while (in_stall);
		pixels_sent++;
	endtask

	// Hold off the sender until every predicted item has come back.
	task automatic wait_for_drain();
		in_valid <= 1'b0;
		do
			@(posedge clk);
		while (pixels_in_flight != 0);
	endtask

	// Pick a component level, biased toward the ends of the range.
	function automatic int pick_level();
		int sel;
		sel = $urandom_range(7);
		if (sel == 0)
			return 0;
		if (sel == 1)
			return COMP_TOP;
		return $urandom_range(COMP_TOP);
	endfunction

	// Pick a hue: half anywhere in the field, some hugging a sector edge,
	// some past a full turn where the block folds back one turn.
	function automatic int pick_hue();
		int sel, h;
		sel = $urandom_range(9);
		if (sel < 5) begin
			h = $urandom_range(HUE_MAX);
		end else if (sel < 8) begin
			h = SECTOR_SPAN * $urandom_range(NUM_SECTORS) + $urandom_range(4) - 2;
			if (h < 0)
				h = 0;
		end else begin
			h = FULL_TURN + $urandom_range(HUE_MAX - FULL_TURN);
		end
		return h;
	endfunction

	initial begin
		// release reset on a rising edge
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: pure red, the full-turn wrap, hues past a full turn,
		// each sector's middle and last step, grey and black, stray top bit.
		recv_stall_pct = 30;
		send_pixel(0, COMP_TOP, COMP_TOP);
		send_pixel(FULL_TURN, COMP_TOP, COMP_TOP);
		send_pixel(FULL_TURN - 1, COMP_TOP, COMP_TOP);
		send_pixel(HUE_MAX, COMP_TOP, COMP_TOP);
		send_pixel(FULL_TURN + SECTOR_SPAN, 200, 180);
		for (int k = 0; k < NUM_SECTORS; k++)
			send_pixel(k * SECTOR_SPAN + SECTOR_SPAN / 2, COMP_TOP, COMP_TOP);
		for (int k = 1; k <= NUM_SECTORS; k++)
			send_pixel(k * SECTOR_SPAN - 1, 170, COMP_TOP);
		send_pixel(5000, 0, COMP_TOP);
		send_pixel(5000, COMP_TOP, 0);
		send_pixel(12345, 0, 0);
		send_pixel(0, 0, 0);
		send_pixel(HUE_MAX, 0, 0);
		send_pixel(1 << (HUE_W - 1), 128, 128);
		send_pixel(1, 1, 1);
		// pause the sender until the pipeline is empty
		wait_for_drain();

		// Random phases, each with its own pacing, drained in between.
		for (int ph = 0; ph < NUM_PHASES; ph++) begin
			send_idle_pct  = phase_send[ph];
			recv_stall_pct = phase_recv[ph];
			for (int n = 0; n < PHASE_ITEMS; n++)
				send_pixel(pick_hue(), pick_level(), pick_level());
			wait_for_drain();
		end

		// let any stray item surface before judging
		recv_stall_pct = 0;
		repeat (4 * LATENCY) @(posedge clk);

		$display("Sent %0d pixels (directed edges plus random hues over the whole field),",
			pixels_sent);
		$display("checked %0d results under four pacing mixes; %0d mismatches.",
			pixels_checked, mismatches);
		if (mismatches == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

	// Watchdog: far beyond the slowest correct run.
	initial begin
		#2_000_000;
		$display("Timeout with %0d items still awaited.", pixels_in_flight);
		$display("Simulation FAILED");
		$finish;
	end

endmodule
